>>> hw/rtl/samp_pkg.sv
`default_nettype none
package samp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned VAL_W         = 32;
  // square root: 66-bit radicand, 33-bit root, 36-bit partial remainder
  localparam int unsigned SQ_W          = 66;
  localparam int unsigned ROOT_W        = 33;
  localparam int unsigned SREM_W        = 36;
  // division: 66-bit divisor, 32-bit quotient
  localparam int unsigned DEN_W         = 66;
  localparam int unsigned QUO_W         = 32;
  localparam int unsigned REM_W         = DEN_W + QUO_W;

  localparam logic [VAL_W-1:0] MAX_VEL_RST = 32'h0001_0000;
  localparam logic [VAL_W-1:0] ACCEL_RST   = 32'h0001_0000;

  typedef enum logic [1:0] {
    CASE_BRAKE   = 2'd0,
    CASE_TRAP    = 2'd1,
    CASE_TRI     = 2'd2,
    CASE_INVALID = 2'd3
  } prof_case_e;

  typedef enum logic {
    CFG_MAX_VEL = 1'b0,
    CFG_ACCEL   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0] vel;
    logic [VAL_W-1:0] accel;
    prof_case_e       pcase;
    logic [DEN_W-1:0] tnum;
    logic [DEN_W-1:0] tden;
  } side_t;

endpackage
`default_nettype wire

>>> hw/rtl/stop_at_end_motion_profile.sv
// Stop-at-end motion profile timer.
// Input channel (in_valid_i / in_ready_o) carries a start speed and a remaining
// distance; output channel (out_valid_o / out_ready_i) returns the minimum
// travel time, arrival speed, profile case and a saturation flag. All values
// are unsigned fixed point with FRAC_BITS fraction bits.
// max_velocity and accel_rate are set through the write port (cfg_we_i,
// cfg_idx_i, cfg_wdata_i); write them only while no request is in flight.
// The pipeline has three multiply and case-select stages, a 33-stage
// square-root pipeline (one root bit each), a prep stage and a 32-stage
// divider (one quotient bit each), then the output register. Throughput: one
// request per cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops, so
// nothing is lost or repeated; in_ready_o is high whenever the output register
// is empty or being drained.
// Reset clears all valid bits and loads both settings with 1.0.
`default_nettype none
module stop_at_end_motion_profile
  import samp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [VAL_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [VAL_W-1:0] start_velocity_i,
  input  wire logic [VAL_W-1:0] remaining_distance_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [VAL_W-1:0]      travel_time_o,
  output logic [VAL_W-1:0]      end_velocity_o,
  output logic [1:0]            profile_case_o,
  output logic                  saturated_o
);

  logic [VAL_W-1:0] max_vel_q, accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q <= MAX_VEL_RST;
      accel_q   <= ACCEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_VEL: max_vel_q <= cfg_wdata_i;
        CFG_ACCEL:   accel_q   <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;

  // advance the pipeline unless a finished result is held and not taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic              f_valid, s_valid, d_valid;
  side_t             f_side, s_side;
  logic [SQ_W-1:0]   f_rad;
  logic [ROOT_W-1:0] s_root;
  logic [VAL_W-1:0]  d_time, d_endv;
  prof_case_e        d_pcase;
  logic              d_sat;

  samp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .vel_i     (start_velocity_i),
    .dist_i    (remaining_distance_i),
    .max_vel_i (max_vel_q),
    .accel_i   (accel_q),
    .valid_o   (f_valid),
    .side_o    (f_side),
    .rad_o     (f_rad)
  );

  samp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .side_i  (f_side),
    .rad_i   (f_rad),
    .valid_o (s_valid),
    .side_o  (s_side),
    .root_o  (s_root)
  );

  samp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .side_i  (s_side),
    .root_i  (s_root),
    .valid_o (d_valid),
    .time_o  (d_time),
    .endv_o  (d_endv),
    .pcase_o (d_pcase),
    .sat_o   (d_sat)
  );

  logic [VAL_W-1:0] time_q, endv_q;
  prof_case_e       pcase_q;
  logic             sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      time_q  <= d_time;
      endv_q  <= d_endv;
      pcase_q <= d_pcase;
      sat_q   <= d_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign travel_time_o  = time_q;
  assign end_velocity_o = endv_q;
  assign profile_case_o = pcase_q;
  assign saturated_o    = sat_q;

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (profile_case_o == CASE_INVALID) |->
      (travel_time_o == '0) && (end_velocity_o == '0) && !saturated_o)
    else $error("invalid case with non-zero result");

  a_endv_brake_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (profile_case_o != CASE_BRAKE) |-> (end_velocity_o == '0))
    else $error("arrival speed outside braking case");

  a_sat_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (travel_time_o == '1))
    else $error("saturated result not clamped");

endmodule
`default_nettype wire

>>> hw/rtl/samp_front.sv
`default_nettype none
module samp_front
  import samp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [VAL_W-1:0] vel_i,
  input  wire logic [VAL_W-1:0] dist_i,
  input  wire logic [VAL_W-1:0] max_vel_i,
  input  wire logic [VAL_W-1:0] accel_i,
  output logic                  valid_o,
  output side_t                 side_o,
  output logic [SQ_W-1:0]       rad_o
);

  // stage 1: v^2 and a*d
  logic             val1_q, inval1_q;
  logic [VAL_W-1:0] v1_q, m1_q, a1_q;
  logic [63:0]      vsq1_q, ad1_q, vsq1_d, ad1_d;
  logic             inval1_d;

  assign vsq1_d   = vel_i * vel_i;
  assign ad1_d    = accel_i * dist_i;
  assign inval1_d = (accel_i == '0) || (max_vel_i == '0) || (vel_i > max_vel_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val1_q <= 1'b0;
    end else if (en_i) begin
      val1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q     <= vel_i;
      m1_q     <= max_vel_i;
      a1_q     <= accel_i;
      vsq1_q   <= vsq1_d;
      ad1_q    <= ad1_d;
      inval1_q <= inval1_d;
    end
  end

  // stage 2: m^2, a*m, (m-v)^2
  logic             val2_q, inval2_q;
  logic [VAL_W-1:0] v2_q, a2_q, dif2;
  logic [63:0]      vsq2_q, ad2_q, mm2_q, am2_q, dmv2_q;
  logic [63:0]      mm2_d, am2_d, dmv2_d;

  assign dif2   = m1_q - v1_q;
  assign mm2_d  = m1_q * m1_q;
  assign am2_d  = a1_q * m1_q;
  assign dmv2_d = dif2 * dif2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val2_q <= 1'b0;
    end else if (en_i) begin
      val2_q <= val1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v2_q     <= v1_q;
      a2_q     <= a1_q;
      vsq2_q   <= vsq1_q;
      ad2_q    <= ad1_q;
      inval2_q <= inval1_q;
      mm2_q    <= mm2_d;
      am2_q    <= am2_d;
      dmv2_q   <= dmv2_d;
    end
  end

  // stage 3: pick the case, form the root argument and trapezoid fraction
  logic        val3_q;
  side_t       side3_q, side3_d;
  logic [SQ_W-1:0] rad3_q, rad3_d;
  logic [62:0] half;
  logic        brake, trap;

  assign half  = vsq2_q[63:1];
  assign brake = ad2_q <= {1'b0, half};
  assign trap  = (mm2_q - {1'b0, half}) <= ad2_q;

  always_comb begin
    side3_d.vel   = v2_q;
    side3_d.accel = a2_q;
    side3_d.tnum  = {2'b00, dmv2_q} + {2'b00, mm2_q} + {1'b0, ad2_q, 1'b0};
    side3_d.tden  = {1'b0, am2_q, 1'b0};
    priority if (inval2_q) begin
      side3_d.pcase = CASE_INVALID;
      rad3_d        = '0;
    end else if (brake) begin
      side3_d.pcase = CASE_BRAKE;
      rad3_d        = {2'b00, vsq2_q} - {1'b0, ad2_q, 1'b0};
    end else if (trap) begin
      side3_d.pcase = CASE_TRAP;
      rad3_d        = '0;
    end else begin
      side3_d.pcase = CASE_TRI;
      rad3_d        = {3'b000, half} + {2'b00, ad2_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val3_q <= 1'b0;
    end else if (en_i) begin
      val3_q <= val2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q <= side3_d;
      rad3_q  <= rad3_d;
    end
  end

  assign valid_o = val3_q;
  assign side_o  = side3_q;
  assign rad_o   = rad3_q;

endmodule
`default_nettype wire

>>> hw/rtl/samp_sqrt.sv
`default_nettype none
module samp_sqrt
  import samp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire side_t             side_i,
  input  wire logic [SQ_W-1:0]   rad_i,
  output logic                   valid_o,
  output side_t                  side_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic              val_q  [ROOT_W];
  side_t             side_q [ROOT_W];
  logic [SQ_W-1:0]   rad_q  [ROOT_W];
  logic [SREM_W-1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  // one root bit per stage, most significant first
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int B = ROOT_W - 1 - s;
    logic              val_in, ge;
    side_t             side_in;
    logic [SQ_W-1:0]   rad_in;
    logic [SREM_W-1:0] rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;

    if (s == 0) begin : g_first
      assign val_in  = valid_i;
      assign side_in = side_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign val_in  = val_q[s-1];
      assign side_in = side_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign rem_sh = {rem_in[SREM_W-3:0], rad_in[2*B+1 -: 2]};
    assign trial  = SREM_W'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[s] <= 1'b0;
      end else if (en_i) begin
        val_q[s] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
        rad_q[s]  <= rad_in;
        rem_q[s]  <= ge ? rem_sh - trial : rem_sh;
        root_q[s] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign valid_o = val_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule
`default_nettype wire

>>> hw/rtl/samp_div.sv
`default_nettype none
module samp_div
  import samp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire side_t             side_i,
  input  wire logic [ROOT_W-1:0] root_i,
  output logic                   valid_o,
  output logic [VAL_W-1:0]       time_o,
  output logic [VAL_W-1:0]       endv_o,
  output prof_case_e             pcase_o,
  output logic                   sat_o
);

  localparam int unsigned NUM_W = DEN_W + FRAC_BITS;

  typedef struct packed {
    prof_case_e       pcase;
    logic [VAL_W-1:0] endv;
    logic             sat;
  } dside_t;

  // prep stage: numerator, divisor and range check
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     den;
  logic [ROOT_W:0]      tri_diff;
  logic [VAL_W-1:0]     brk_diff;
  logic                 sat_d;
  dside_t               dside_d;

  assign brk_diff = side_i.vel - root_i[VAL_W-1:0];
  assign tri_diff = {root_i, 1'b0} - (ROOT_W+1)'(side_i.vel);

  always_comb begin
    unique case (side_i.pcase)
      CASE_BRAKE: begin
        num = NUM_W'(brk_diff) << FRAC_BITS;
        den = DEN_W'(side_i.accel);
      end
      CASE_TRAP: begin
        num = NUM_W'(side_i.tnum) << FRAC_BITS;
        den = side_i.tden;
      end
      CASE_TRI: begin
        num = NUM_W'(tri_diff) << FRAC_BITS;
        den = DEN_W'(side_i.accel);
      end
      default: begin
        num = '0;
        den = DEN_W'(1);
      end
    endcase
  end

  assign sat_d         = REM_W'(num) >= {den, QUO_W'(0)};
  assign dside_d.pcase = side_i.pcase;
  assign dside_d.endv  = (side_i.pcase == CASE_BRAKE) ? root_i[VAL_W-1:0] : '0;
  assign dside_d.sat   = sat_d;

  logic             valp_q;
  logic [REM_W-1:0] remp_q;
  logic [DEN_W-1:0] denp_q;
  dside_t           dsidep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valp_q <= 1'b0;
    end else if (en_i) begin
      valp_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      remp_q   <= sat_d ? '0 : REM_W'(num);
      denp_q   <= den;
      dsidep_q <= dside_d;
    end
  end

  // one quotient bit per stage, most significant first
  logic             val_q  [QUO_W];
  logic [REM_W-1:0] rem_q  [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  dside_t           dside_q[QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic             val_in, ge;
    logic [REM_W-1:0] rem_in, part;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    dside_t           dside_in;

    if (s == 0) begin : g_first
      assign val_in   = valp_q;
      assign rem_in   = remp_q;
      assign den_in   = denp_q;
      assign quo_in   = '0;
      assign dside_in = dsidep_q;
    end else begin : g_next
      assign val_in   = val_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign den_in   = den_q[s-1];
      assign quo_in   = quo_q[s-1];
      assign dside_in = dside_q[s-1];
    end

    assign part = REM_W'(den_in) << B;
    assign ge   = rem_in >= part;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[s] <= 1'b0;
      end else if (en_i) begin
        val_q[s] <= val_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]   <= ge ? rem_in - part : rem_in;
        den_q[s]   <= den_in;
        quo_q[s]   <= {quo_in[QUO_W-2:0], ge};
        dside_q[s] <= dside_in;
      end
    end
  end

  assign valid_o = val_q[QUO_W-1];
  assign time_o  = dside_q[QUO_W-1].sat ? '1 : quo_q[QUO_W-1];
  assign endv_o  = dside_q[QUO_W-1].endv;
  assign pcase_o = dside_q[QUO_W-1].pcase;
  assign sat_o   = dside_q[QUO_W-1].sat;

endmodule
`default_nettype wire

>>> sim/stop_at_end_motion_profile_tb.sv
`timescale 1ns / 100ps
module stop_at_end_motion_profile_tb;
  import samp_pkg::*;

  localparam int unsigned FB = 16;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct {
    logic [31:0] ttime;
    logic [31:0] evel;
    prof_case_e  pcase;
    logic        sat;
  } plan_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] start_velocity_i = '0;
  logic [31:0] remaining_distance_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] travel_time_o;
  logic [31:0] end_velocity_o;
  logic [1:0]  profile_case_o;
  logic        saturated_o;

  stop_at_end_motion_profile dut (.*);

  always #4 clk_i = ~clk_i;

  logic [31:0] vmax = 32'h0001_0000;
  logic [31:0] accel = 32'h0001_0000;
  plan_t       plan_q[$];
  int          err_cnt = 0;
  int          checked = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          case_seen[4] = '{0, 0, 0, 0};
  int          sat_seen = 0;

  function automatic logic [67:0] isqrt(logic [67:0] x);
    logic [67:0] r;
    logic [67:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (68'd1 << b);
      if (136'(c) * 136'(c) <= 136'(x)) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] div_sat(logic [127:0] num, logic [127:0] den,
                                          output logic sat);
    logic [127:0] q;
    q = num / den;
    sat = (q > 128'hFFFF_FFFF);
    return sat ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic plan_t plan_travel(logic [31:0] v, logic [31:0] d);
    plan_t       p;
    logic [127:0] vv, ad, half, m, num;
    logic [67:0] pk;
    p.ttime = '0; p.evel = '0; p.sat = 1'b0; p.pcase = CASE_INVALID;
    if (accel == 0 || vmax == 0 || v > vmax) return p;
    vv = 128'(v) * v;
    ad = 128'(accel) * d;
    half = vv >> 1;
    m = 128'(vmax);
    if (ad <= half) begin
      p.evel = 32'(isqrt(68'(vv - 2 * ad)));
      p.ttime = div_sat((128'(v) - p.evel) << FB, 128'(accel), p.sat);
      p.pcase = CASE_BRAKE;
    end else if (m * m - half <= ad) begin
      num = (m - v) * (m - v) + m * m + 2 * ad;
      p.ttime = div_sat(num << FB, 2 * 128'(accel) * m, p.sat);
      p.pcase = CASE_TRAP;
    end else begin
      pk = isqrt(68'(half + ad));
      p.ttime = div_sat((2 * 128'(pk) - v) << FB, 128'(accel), p.sat);
      p.pcase = CASE_TRI;
    end
    return p;
  endfunction

  task automatic send_request(logic [31:0] v, logic [31:0] d);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_velocity_i <= v;
    remaining_distance_i <= d;
    plan_q.push_back(plan_travel(v, d));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin
    if (recv_stall > 0 && $urandom_range(99) < recv_stall) out_ready_i <= 1'b0;
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    plan_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      checked++;
      if (plan_q.size() == 0) begin
        $display("%0t: result with nothing expected, got t=%h e=%h c=%0d s=%b", $time,
                 travel_time_o, end_velocity_o, profile_case_o, saturated_o);
        err_cnt++;
      end else begin
        x = plan_q.pop_front();
        case_seen[x.pcase]++;
        if (x.sat) sat_seen++;
        if (travel_time_o !== x.ttime || end_velocity_o !== x.evel ||
            profile_case_o !== x.pcase || saturated_o !== x.sat) begin
          $display("%0t: mismatch exp t=%h e=%h c=%0d s=%b got t=%h e=%h c=%0d s=%b",
                   $time, x.ttime, x.evel, x.pcase, x.sat, travel_time_o,
                   end_velocity_o, profile_case_o, saturated_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_MAX_VEL) vmax = val; else accel = val;
  endtask

  task automatic set_limits(logic [31:0] m, logic [31:0] a);
    drain();
    write_cfg(CFG_MAX_VEL, m);
    write_cfg(CFG_ACCEL, a);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(255);
      1: return $urandom_range(32'h0004_0000);
      2: return ~32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_settings();
    send_request(32'h0000_8000, 32'h0000_0100);
    send_request(32'h0001_0000, 32'h0000_0000);
    send_request(32'h0, 32'h0010_0000);
    send_request(32'h0, 32'h0000_4000);
    send_request(32'h0001_0001, 32'h0001_0000);
  endtask

  task automatic test_directed_corners();
    set_limits(32'hFFFF_FFFF, 32'h0000_0001);
    send_request(32'h0, 32'h0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'h0);
    send_request(32'h8000_0000, 32'h0000_1000);
    set_limits(32'h0000_0001, 32'hFFFF_FFFF);
    send_request(32'h1, 32'hFFFF_FFFF);
    send_request(32'h0, 32'h1);
    send_request(32'h2, 32'h1);
    set_limits(32'h0002_0000, 32'h0);
    send_request(32'h0001_0000, 32'h0001_0000);
    set_limits(32'h0, 32'h0001_0000);
    send_request(32'h0, 32'h0001_0000);
    set_limits(32'h0010_0000, 32'h0000_8000);
    send_request(32'h0008_0000, 32'h0001_0000);
    send_request(32'h0008_0000, 32'h0100_0000);
    send_request(32'h0008_0000, 32'h0008_0000);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    logic [31:0] v;
    send_idle = idle;
    recv_stall = stall;
    set_limits(rand_word(), ($urandom_range(19) == 0) ? 32'h0 : rand_word());
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(9) == 0 || vmax == 0) ? rand_word() : $urandom_range(vmax);
      send_request(v, rand_word());
    end
  endtask

  task automatic test_random_traffic();
    int idle[4] = '{0, 49, 0, 38};
    int stall[4] = '{0, 0, 49, 38};
    for (int k = 0; k < 40; k++)
      random_phase(50, idle[k % 4], stall[k % 4]);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_settings();
    test_directed_corners();
    test_random_traffic();
    drain();
    $display("Checked %0d results: braking %0d, trapezoid %0d, triangle %0d, invalid %0d",
             checked, case_seen[0], case_seen[1], case_seen[2], case_seen[3]);
    $display("Clamped travel times seen: %0d", sat_seen);
    if (err_cnt == 0 && plan_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", plan_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/samp_pkg.sv
hw/rtl/samp_front.sv
hw/rtl/samp_sqrt.sv
hw/rtl/samp_div.sv
hw/rtl/stop_at_end_motion_profile.sv
sim/stop_at_end_motion_profile_tb.sv
